### rtl/ols_pkg.sv
// ----------------------------------------------------------------------------
// ols_pkg: shared types and codes for the ordered list store
// Command and status codes, cell operation codes, the controller state type
// and the control word broadcast along the row of cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ols_pkg;

	// Largest supported list depth; positions on the cell bus are sized for it.
	localparam int MAX_CAPACITY = 1024;
	localparam int POS_W = $clog2(MAX_CAPACITY + 1);

	// Command codes of the input word.
	typedef enum logic [2:0] {
		CMD_SET       = 3'd0,
		CMD_PUSH_BACK = 3'd1,
		CMD_INSERT    = 3'd2,
		CMD_POP_BACK  = 3'd3,
		CMD_POP_FRONT = 3'd4,
		CMD_SPLICE    = 3'd5
	} cmd_t;

	// Status codes of the result word.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	// What every cell does in a cycle, relative to the broadcast position.
	typedef enum logic [1:0] {
		CELL_HOLD,   // keep contents
		CELL_WRITE,  // the cell at pos loads the new value
		CELL_INSERT, // cell at pos loads the value, cells above take the left neighbor
		CELL_SHIFT   // cells at pos and above take the right neighbor
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] rd_pos;
	} cell_ctrl_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_SHIFTING
	} state_t;

endpackage

`default_nettype wire

### rtl/ols_cell.sv
// ----------------------------------------------------------------------------
// ols_cell: one position of the ordered list
// Holds one element and, under the broadcast control word, keeps it, loads the
// new value, or takes the element of its left or right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module ols_cell import ols_pkg::*; #(
	parameter int IDX = 0,
	parameter int EW  = 32
) (
	input  wire logic          clk,
	input  wire cell_ctrl_t    ctrl,
	input  wire logic [EW-1:0] value,
	input  wire logic [EW-1:0] left_data,
	input  wire logic [EW-1:0] right_data,
	output logic      [EW-1:0] data_q,
	output logic      [EW-1:0] rd_data
);

	localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

	logic [EW-1:0] data_d;

	// Pick the next contents from the operation and this cell's place.
	always_comb begin
		data_d = data_q;
		case (ctrl.op)
			CELL_WRITE: begin
				if (ctrl.pos == MY_POS) data_d = value;
			end
			CELL_INSERT: begin
				if (ctrl.pos == MY_POS) data_d = value;
				else if (MY_POS > ctrl.pos) data_d = left_data;
			end
			CELL_SHIFT: begin
				if (MY_POS >= ctrl.pos) data_d = right_data;
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	// Element storage; contents have no meaning until written.
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	// Only the addressed cell drives the read bus.
	assign rd_data = (ctrl.rd_pos == MY_POS) ? data_q : '0;

endmodule

`default_nettype wire

### rtl/ols_ctrl.sv
// ----------------------------------------------------------------------------
// ols_ctrl: command decoder and sequencer of the ordered list store
// Checks each command against the count, drives the cell control word,
// repeats single-step shifts for a splice, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ols_ctrl import ols_pkg::*; #(
	parameter int CAPACITY = 64,
	parameter int EW       = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [2:0]                           command,
	input  wire logic [$clog2(CAPACITY+1)-1:0]        index,
	input  wire logic signed [7:0]                    run_length,
	input  wire logic [EW-1:0]                        rd_data,
	output cell_ctrl_t                                ctrl,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [EW-1:0]                             removed_value,
	output logic [$clog2(CAPACITY+1)-1:0]             element_count,
	output logic [1:0]                                status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int W = (CNT_W > 8) ? CNT_W : 8;
	localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [W-1:0]     rem_q;
	logic [POS_W-1:0] pos_q;
	logic             ovalid_q;
	logic [EW-1:0]    removed_q;
	logic [CNT_W-1:0] ocount_q;
	logic [1:0]       status_q;

	logic             accept;
	cell_op_t         dec_op;
	logic [POS_W-1:0] dec_pos;
	logic [POS_W-1:0] dec_rd_pos;
	logic [1:0]       dec_status;
	logic [CNT_W-1:0] dec_count;
	logic             dec_take;
	logic [W-1:0]     avail;
	logic [W-1:0]     run_req;
	logic [W-1:0]     run;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE) && (!ovalid_q || out_ready);

	// Splice length: a negative request runs to the end, a long one is clamped.
	always_comb begin
		avail   = W'(count_q) - W'(index);
		run_req = run_length[7] ? avail : W'(run_length[6:0]);
		run     = (run_req > avail) ? avail : run_req;
	end

	// Command decode against the current count.
	always_comb begin
		dec_op     = CELL_HOLD;
		dec_pos    = POS_W'(index);
		dec_rd_pos = '0;
		dec_status = ST_OK;
		dec_count  = count_q;
		dec_take   = 1'b0;
		case (cmd_t'(command))
			CMD_SET: begin
				if (index < count_q) dec_op = CELL_WRITE;
				else dec_status = ST_RANGE;
			end
			CMD_PUSH_BACK: begin
				if (count_q >= CAP) begin
					dec_status = ST_FULL;
				end else begin
					dec_op    = CELL_WRITE;
					dec_pos   = POS_W'(count_q);
					dec_count = count_q + 1'b1;
				end
			end
			CMD_INSERT: begin
				if (count_q >= CAP) begin
					dec_status = ST_FULL;
				end else if (index > count_q) begin
					dec_status = ST_RANGE;
				end else begin
					dec_op    = CELL_INSERT;
					dec_count = count_q + 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (count_q == '0) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_rd_pos = POS_W'(count_q - 1'b1);
					dec_take   = 1'b1;
					dec_count  = count_q - 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (count_q == '0) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_op    = CELL_SHIFT;
					dec_pos   = '0;
					dec_take  = 1'b1;
					dec_count = count_q - 1'b1;
				end
			end
			CMD_SPLICE: begin
				if (count_q == '0) begin
					dec_status = ST_EMPTY;
				end else if (index > count_q) begin
					dec_status = ST_RANGE;
				end else if (run != '0) begin
					dec_op    = CELL_SHIFT;
					dec_count = count_q - CNT_W'(run);
				end
			end
			default: begin
				dec_op = CELL_HOLD;
			end
		endcase
	end

	// Next state: a splice of more than one element keeps shifting.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (cmd_t'(command) == CMD_SPLICE) && (dec_op == CELL_SHIFT)
					&& (run > W'(1)))
					state_d = ST_SHIFTING;
			end
			ST_SHIFTING: begin
				if (rem_q == W'(1)) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Cell control word for this cycle.
	always_comb begin
		ctrl.op     = CELL_HOLD;
		ctrl.pos    = dec_pos;
		ctrl.rd_pos = dec_rd_pos;
		case (state_q)
			ST_IDLE: begin
				if (accept) ctrl.op = dec_op;
			end
			ST_SHIFTING: begin
				ctrl.op  = CELL_SHIFT;
				ctrl.pos = pos_q;
			end
			default: begin
				ctrl.op = CELL_HOLD;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			rem_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				count_q  <= dec_count;
				rem_q    <= run - W'(1);
				ovalid_q <= 1'b1;
			end else begin
				if (state_q == ST_SHIFTING) rem_q <= rem_q - W'(1);
				if (out_ready) ovalid_q <= 1'b0;
			end
		end
	end

	// Result word and splice start position.
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q     <= dec_pos;
			removed_q <= dec_take ? rd_data : '0;
			ocount_q  <= dec_count;
			status_q  <= dec_status;
		end
	end

	assign out_valid     = ovalid_q;
	assign removed_value = removed_q;
	assign element_count = ocount_q;
	assign status        = status_q;

endmodule

`default_nettype wire

### rtl/ordered_list_store.sv
// ----------------------------------------------------------------------------
// ordered_list_store: fixed-capacity ordered list of elements
// A row of cells, one per position, shifts the list up for insert and down
// for pop front and splice; a controller checks each command and returns the
// removed element, the new count and a status.
// ----------------------------------------------------------------------------
//
//   channel  handshake              payload
//   input    in_valid / in_ready    command, index, run_length, value
//   output   out_valid / out_ready  removed_value, element_count, status
//
// Set, push back, insert, pop back and pop front each finish when the word is
// accepted; a word is accepted every cycle while results are taken. A splice
// that removes n elements does n single-position shifts of the cell row, and
// no word is accepted until the last shift. Its result is registered at the
// first shift. Reset clears the count and the result valid; cells are not
// cleared. A stalled result register blocks the input only until it is taken.
//
`default_nettype none

module ordered_list_store import ols_pkg::*; #(
	parameter int CAPACITY      = 64,
	parameter int ELEMENT_WIDTH = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [2:0]                           command,
	input  wire logic [$clog2(CAPACITY+1)-1:0]        index,
	input  wire logic signed [7:0]                    run_length,
	input  wire logic [ELEMENT_WIDTH-1:0]             value,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [ELEMENT_WIDTH-1:0]                  removed_value,
	output logic [$clog2(CAPACITY+1)-1:0]             element_count,
	output logic [1:0]                                status
);

	localparam int EW = ELEMENT_WIDTH;

	cell_ctrl_t    ctrl;
	logic [EW-1:0] cell_data [CAPACITY];
	logic [EW-1:0] cell_rd   [CAPACITY];
	logic [EW-1:0] rd_data;

	// Read bus: at most one cell drives nonzero data.
	always_comb begin
		rd_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_data = rd_data | cell_rd[i];
		end
	end

	ols_ctrl #(
		.CAPACITY(CAPACITY),
		.EW      (EW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.index        (index),
		.run_length   (run_length),
		.rd_data      (rd_data),
		.ctrl         (ctrl),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.removed_value(removed_value),
		.element_count(element_count),
		.status       (status)
	);

	// Row of cells, each linked to its neighbors.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [EW-1:0] left_w;
		logic [EW-1:0] right_w;

		if (g == 0) begin : g_first
			assign left_w = value;
		end else begin : g_mid_l
			assign left_w = cell_data[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[g+1];
		end

		ols_cell #(
			.IDX(g),
			.EW (EW)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.value     (value),
			.left_data (left_w),
			.right_data(right_w),
			.data_q    (cell_data[g]),
			.rd_data   (cell_rd[g])
		);
	end

endmodule

`default_nettype wire

### bench/tb_ordered_list_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_store: self-checking bench for the ordered list store
// A table of directed commands covers the empty and full list, range errors,
// splice clamping and the unused command codes. Random command streams then
// fill and drain the list. Every result word is checked against the table
// or a shadow list in the bench, under bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ordered_list_store;
	import ols_pkg::*;

	localparam int CAPACITY    = 64;
	localparam int ELEM_W      = 32;
	localparam int COUNT_W     = $clog2(CAPACITY + 1);
	localparam int RANDOM_CMDS = 1680;
	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_WAIT  = 80;
	localparam int HOLD_CYCLES = 250;

	// Command codes with no function; the block must ignore them.
	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;

	typedef struct packed {
		logic [2:0]         command;
		logic [COUNT_W-1:0] index;
		logic signed [7:0]  run_length;
		logic [ELEM_W-1:0]  value;
	} list_cmd_t;

	typedef struct packed {
		logic [ELEM_W-1:0]  removed;
		logic [COUNT_W-1:0] count;
		logic [1:0]         status;
	} list_result_t;

	// One row of the directed table: the word, how often it is sent (value
	// counts up on each repeat) and an optional hand-written result.
	typedef struct packed {
		list_cmd_t    word;
		logic [6:0]   repeats;
		logic         typed;
		list_result_t res;
	} directed_row_t;

	typedef enum logic [1:0] {
		LOAD_MIX,
		LOAD_FILL,
		LOAD_DRAIN
	} load_mode_t;

	localparam int N_ROWS = 26;
	localparam directed_row_t DIRECTED_ROWS [N_ROWS] = '{
		'{'{CMD_POP_BACK,  7'd0,  -8'sd1, 32'h0000_0000}, 7'd1,  1'b1, '{32'd0, 7'd0,  ST_EMPTY}},
		'{'{CMD_POP_FRONT, 7'd0,  8'sd0,  32'h0000_0000}, 7'd1,  1'b1, '{32'd0, 7'd0,  ST_EMPTY}},
		'{'{CMD_SPLICE,    7'd0,  -8'sd1, 32'h0000_0000}, 7'd1,  1'b1, '{32'd0, 7'd0,  ST_EMPTY}},
		'{'{CMD_SPLICE,    7'd64, 8'sd64, 32'h0000_0000}, 7'd1,  1'b1, '{32'd0, 7'd0,  ST_EMPTY}},
		'{'{CMD_SET,       7'd0,  8'sd0,  32'hFFFF_FFFF}, 7'd1,  1'b1, '{32'd0, 7'd0,  ST_RANGE}},
		'{'{CMD_INSERT,    7'd1,  8'sd0,  32'h1111_1111}, 7'd1,  1'b1, '{32'd0, 7'd0,  ST_RANGE}},
		'{'{CMD_INSERT,    7'd0,  8'sd0,  32'hFFFF_FFFF}, 7'd1,  1'b1, '{32'd0, 7'd1,  ST_OK}},
		'{'{CMD_PUSH_BACK, 7'd0,  8'sd0,  32'h0000_0000}, 7'd1,  1'b1, '{32'd0, 7'd2,  ST_OK}},
		'{'{CMD_PUSH_BACK, 7'd0,  8'sd0,  32'hA5A5_5A5A}, 7'd1,  1'b0, '0},
		'{'{CMD_INSERT,    7'd1,  8'sd0,  32'h1234_5678}, 7'd1,  1'b0, '0},
		'{'{CMD_SET,       7'd3,  8'sd0,  32'hDEAD_BEEF}, 7'd1,  1'b0, '0},
		'{'{CMD_SET,       7'd4,  8'sd0,  32'h0000_0001}, 7'd1,  1'b1, '{32'd0, 7'd4,  ST_RANGE}},
		'{'{CMD_SPARE_A,   7'd0,  8'sd0,  32'h0000_0000}, 7'd1,  1'b1, '{32'd0, 7'd4,  ST_OK}},
		'{'{CMD_SPARE_B,   7'd0,  8'sd0,  32'h0000_0000}, 7'd1,  1'b1, '{32'd0, 7'd4,  ST_OK}},
		'{'{CMD_POP_FRONT, 7'd0,  8'sd0,  32'h0000_0000}, 7'd1,  1'b0, '0},
		'{'{CMD_POP_BACK,  7'd0,  8'sd0,  32'h0000_0000}, 7'd1,  1'b0, '0},
		'{'{CMD_SPLICE,    7'd2,  8'sd5,  32'h0000_0000}, 7'd1,  1'b0, '0},
		'{'{CMD_SPLICE,    7'd3,  8'sd1,  32'h0000_0000}, 7'd1,  1'b1, '{32'd0, 7'd2,  ST_RANGE}},
		'{'{CMD_SPLICE,    7'd0,  8'sd0,  32'h0000_0000}, 7'd1,  1'b0, '0},
		'{'{CMD_PUSH_BACK, 7'd0,  8'sd0,  32'h8000_0000}, 7'd62, 1'b0, '0},
		'{'{CMD_PUSH_BACK, 7'd0,  8'sd0,  32'h7777_7777}, 7'd1,  1'b1, '{32'd0, 7'd64, ST_FULL}},
		'{'{CMD_INSERT,    7'd0,  8'sd0,  32'h7777_7777}, 7'd1,  1'b1, '{32'd0, 7'd64, ST_FULL}},
		'{'{CMD_INSERT,    7'd64, 8'sd0,  32'h7777_7777}, 7'd1,  1'b1, '{32'd0, 7'd64, ST_FULL}},
		'{'{CMD_SET,       7'd63, 8'sd0,  32'hC0DE_0001}, 7'd1,  1'b0, '0},
		'{'{CMD_SPLICE,    7'd60, 8'sd64, 32'h0000_0000}, 7'd1,  1'b0, '0},
		'{'{CMD_SPLICE,    7'd0,  -8'sd1, 32'h0000_0000}, 7'd1,  1'b1, '{32'd0, 7'd0,  ST_OK}}
	};

	logic                      clk;
	logic                      arst_n        = 1'b0;
	logic                      in_valid      = 1'b0;
	logic                      in_ready;
	logic [2:0]                command       = '0;
	logic [COUNT_W-1:0]        index         = '0;
	logic signed [7:0]         run_length    = '0;
	logic [ELEM_W-1:0]         value         = '0;
	logic                      out_valid;
	logic                      out_ready     = 1'b0;
	logic [ELEM_W-1:0]         removed_value;
	logic [COUNT_W-1:0]        element_count;
	logic [1:0]                status;

	// Shadow copy of the list and the results still owed by the block.
	logic [ELEM_W-1:0]         list_mem [CAPACITY];
	int                        list_len      = 0;
	list_result_t              pending_results [$];

	int                        mismatch_count = 0;
	int                        results_taken  = 0;
	int                        burst_left     = 0;
	int                        hold_left      = 0;
	int                        rx_pattern     = 0;
	int                        rx_phase_cnt   = 0;
	int                        idle_cycles    = 0;

	ordered_list_store #(
		.CAPACITY(CAPACITY),
		.ELEMENT_WIDTH(ELEM_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.index(index),
		.run_length(run_length),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.removed_value(removed_value),
		.element_count(element_count),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Applies one command to the shadow list and returns the result it owes.
	function automatic list_result_t apply_list_command(list_cmd_t w);
		list_result_t r;
		int           pos;
		int           avail;
		int           run;
		r   = '0;
		pos = int'(w.index);
		r.status = ST_OK;
		case (w.command)
			CMD_SET: begin
				if (pos < list_len)
					list_mem[pos] = w.value;
				else
					r.status = ST_RANGE;
			end
			CMD_PUSH_BACK: begin
				if (list_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					list_mem[list_len] = w.value;
					list_len++;
				end
			end
			CMD_INSERT: begin
				if (list_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else if (pos > list_len) begin
					r.status = ST_RANGE;
				end else begin
					for (int i = list_len; i > pos; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[pos] = w.value;
					list_len++;
				end
			end
			CMD_POP_BACK: begin
				if (list_len == 0) begin
					r.status = ST_EMPTY;
				end else begin
					list_len--;
					r.removed = list_mem[list_len];
				end
			end
			CMD_POP_FRONT: begin
				if (list_len == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.removed = list_mem[0];
					for (int i = 1; i < list_len; i++)
						list_mem[i-1] = list_mem[i];
					list_len--;
				end
			end
			CMD_SPLICE: begin
				if (list_len == 0) begin
					r.status = ST_EMPTY;
				end else if (pos > list_len) begin
					r.status = ST_RANGE;
				end else begin
					// A negative run removes through the end; long runs are clamped.
					avail = list_len - pos;
					run   = w.run_length[7] ? avail : int'(unsigned'(w.run_length));
					if (run > avail)
						run = avail;
					for (int i = pos; i + run < list_len; i++)
						list_mem[i] = list_mem[i+run];
					list_len -= run;
				end
			end
			default: ;
		endcase
		r.count = list_len[COUNT_W-1:0];
		return r;
	endfunction

	// Offers one word in bursts with random gaps and records its result once
	// the block takes it.
	task automatic send_word(input list_cmd_t w, input logic typed,
			input list_result_t typed_res);
		int           gap;
		list_result_t predicted;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 99) < 50) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 20);
		end
		burst_left--;
		in_valid   <= 1'b1;
		command    <= w.command;
		index      <= w.index;
		run_length <= w.run_length;
		value      <= w.value;
		do
			@(posedge clk);
		while (!in_ready);
		predicted = apply_list_command(w);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	// Builds a random word; the load mode steers the list toward full or empty.
	function automatic list_cmd_t random_word(load_mode_t mode);
		list_cmd_t w;
		int        pick;
		int        hi;
		pick = $urandom_range(0, 99);
		w.value = $urandom;
		case (mode)
			LOAD_FILL:
				w.command = (pick < 40) ? CMD_PUSH_BACK : (pick < 75) ? CMD_INSERT :
					(pick < 88) ? CMD_SET : (pick < 93) ? CMD_POP_BACK :
					(pick < 97) ? CMD_POP_FRONT : CMD_SPLICE;
			LOAD_DRAIN:
				w.command = (pick < 25) ? CMD_POP_BACK : (pick < 50) ? CMD_POP_FRONT :
					(pick < 68) ? CMD_SPLICE : (pick < 78) ? CMD_SET :
					(pick < 89) ? CMD_PUSH_BACK : CMD_INSERT;
			default:
				w.command = (pick < 17) ? CMD_SET : (pick < 34) ? CMD_PUSH_BACK :
					(pick < 51) ? CMD_INSERT : (pick < 67) ? CMD_POP_BACK :
					(pick < 83) ? CMD_POP_FRONT : (pick < 99) ? CMD_SPLICE :
					CMD_SPARE_A;
		endcase
		// Mostly legal positions, sometimes anywhere from 0 to the capacity.
		hi = (w.command == CMD_SET && list_len > 0) ? list_len - 1 : list_len;
		if ($urandom_range(0, 99) < 85)
			w.index = COUNT_W'($urandom_range(0, hi));
		else
			w.index = COUNT_W'($urandom_range(0, CAPACITY));
		pick = $urandom_range(0, 99);
		if (pick < 20)
			w.run_length = -8'sd1;
		else if (pick < 80)
			w.run_length = 8'($urandom_range(0, 4));
		else
			w.run_length = 8'($urandom_range(0, CAPACITY));
		return w;
	endfunction

	// Main sequence: reset, directed table, random streams, final drain.
	initial begin
		list_cmd_t  w;
		load_mode_t mode;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_ROWS; r++) begin
			for (int k = 0; k < DIRECTED_ROWS[r].repeats; k++) begin
				w = DIRECTED_ROWS[r].word;
				w.value = w.value + ELEM_W'(k);
				send_word(w, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res);
			end
		end

		mode = LOAD_FILL;
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			if (n % 150 == 0)
				mode = (n == 0) ? LOAD_FILL : load_mode_t'($urandom_range(0, 2));
			w = random_word(mode);
			send_word(w, 1'b0, '0);
		end
		in_valid <= 1'b0;

		// Wait for the owed results, then give a long splice time to finish.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Result side: check each taken word and drive the stall pattern.
	always @(posedge clk) begin
		list_result_t exp_res;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected result word removed=%h count=%0d status=%0d",
							$realtime, removed_value, element_count, status);
				end else begin
					exp_res = pending_results.pop_front();
					if (removed_value !== exp_res.removed || element_count !== exp_res.count ||
							status !== exp_res.status) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: mismatch removed %h/%h count %0d/%0d status %0d/%0d %s",
								$realtime, exp_res.removed, removed_value, exp_res.count,
								element_count, exp_res.status, status, "(expected/actual)");
					end
				end
				results_taken++;
				// A long hold-off lets the block fill up and stall its input.
				if (results_taken % 800 == 400)
					hold_left = HOLD_CYCLES;
			end

			rx_phase_cnt++;
			if (rx_phase_cnt % 200 == 0)
				rx_pattern = $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_pattern)
					0: out_ready <= 1'b1;
					1: out_ready <= (rx_phase_cnt % 4) != 0;
					2: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

endmodule

`default_nettype wire
